// ===== hw/rtl/cek7_pkg.sv =====
// ----------------------------------------------------------------------------
// cek7_pkg: shared definitions for the K=7 punctured convolutional encoder
// Generator tap masks, history width and the packer result type.
// ----------------------------------------------------------------------------
package cek7_pkg;

  localparam int unsigned HIST_W   = 6;
  localparam int unsigned BYTE_W   = 8;

  // Taps on the history for generator 133 (bits 4, 3, 1, 0) and 171 (bits 5, 4, 3, 0)
  localparam logic [HIST_W-1:0] G0_TAPS = 6'b011011;
  localparam logic [HIST_W-1:0] G1_TAPS = 6'b111001;

  // Code rate register values
  localparam logic RATE_HALF      = 1'b0;
  localparam logic RATE_TWO_THIRD = 1'b1;

  // Completed bytes produced by one input byte
  typedef struct packed {
    logic [1:0]        n_bytes;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
  } pack_result_t;

endpackage

// ===== hw/rtl/conv_encoder_k7_punctured.sv =====
// ----------------------------------------------------------------------------
// conv_encoder_k7_punctured: K=7 (133, 171) encoder with rate 2/3 puncturing
// Encodes one data byte per transfer and returns packed coded bytes.
// ----------------------------------------------------------------------------
// Each accepted data byte runs through a chain of eight encoder cells in the
// cycle it is accepted, and its coded bits are packed behind the partial byte
// left by the previous input. Completed bytes (two at rate 1/2, one or two at
// rate 2/3) go to a two-entry output buffer and leave one per cycle while
// out_ready is high. A new byte is taken only when the buffer is empty or in
// the cycle the last buffered result transfers. A byte flagged last_in_frame
// clears the history and drops any partial byte after it is encoded.
// code_rate may be written only while the block is idle.
// ----------------------------------------------------------------------------
module conv_encoder_k7_punctured (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_in_frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] coded_byte,
  output logic       last_of_run
);

  logic                          code_rate;
  logic [cek7_pkg::HIST_W-1:0]   history;
  logic [cek7_pkg::HIST_W-1:0]   hist_chain [0:8];
  logic [7:0]                    g0;
  logic [7:0]                    g1;
  logic                          in_xfer;
  logic                          out_xfer;
  cek7_pkg::pack_result_t        pack;
  logic [1:0]                    cnt;
  logic [7:0]                    slot0;
  logic [7:0]                    slot1;
  logic                          slot0_last;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Hold the code rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_rate <= cek7_pkg::RATE_HALF;
    end else if (cfg_write) begin
      code_rate <= cfg_wdata;
    end
  end

  // Chain the encoder cells, MSB of the data byte first
  assign hist_chain[0] = history;
  for (genvar k = 0; k < 8; k++) begin : g_cell
    cek7_cell u_cell (
      .bit_in   (data_byte[7-k]),
      .hist_in  (hist_chain[k]),
      .g0       (g0[k]),
      .g1       (g1[k]),
      .hist_out (hist_chain[k+1])
    );
  end

  // Advance the history, clear it at end of frame
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (in_xfer) begin
      history <= last_in_frame ? '0 : hist_chain[8];
    end
  end

  cek7_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .load      (in_xfer),
    .last      (last_in_frame),
    .code_rate (code_rate),
    .g0        (g0),
    .g1        (g1),
    .result    (pack)
  );

  // Take a new byte once the buffer drains this cycle
  assign in_ready = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  // Load completed bytes, shift the buffer on each output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_xfer) begin
      cnt <= pack.n_bytes;
    end else if (out_xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      slot0      <= pack.byte0;
      slot1      <= pack.byte1;
      slot0_last <= (pack.n_bytes == 2'd1);
    end else if (out_xfer) begin
      slot0      <= slot1;
      slot0_last <= 1'b1;
    end
  end

  assign out_valid   = (cnt != 2'd0);
  assign coded_byte  = slot0;
  assign last_of_run = slot0_last;

  // Rate 1/2 always yields two bytes per input byte
  a_half_two_bytes: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (code_rate == cek7_pkg::RATE_HALF) |=> cnt == 2'd2)
    else $error("rate 1/2 input did not yield two bytes");

  // With two bytes buffered the head is never the last of its run
  a_head_not_last: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !slot0_last)
    else $error("head flagged last with a second byte pending");

  // A single buffered byte always closes its run
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd1) |-> slot0_last)
    else $error("lone buffered byte not flagged last");

  // The buffer never holds more than two bytes
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output buffer overflow");

endmodule

// ===== hw/rtl/cek7_cell.sv =====
// ----------------------------------------------------------------------------
// cek7_cell: one encoder step of the bit chain
// Takes one data bit and the incoming history, emits both coded bits and
// hands the shifted history to the next cell.
// ----------------------------------------------------------------------------
module cek7_cell (
  input  logic                      bit_in,
  input  logic [cek7_pkg::HIST_W-1:0] hist_in,
  output logic                      g0,
  output logic                      g1,
  output logic [cek7_pkg::HIST_W-1:0] hist_out
);

  // Form parity over the tapped history bits plus the new bit
  assign g0 = bit_in ^ (^(hist_in & cek7_pkg::G0_TAPS));
  assign g1 = bit_in ^ (^(hist_in & cek7_pkg::G1_TAPS));

  // Shift the new bit in at the top, drop the oldest
  assign hist_out = {bit_in, hist_in[cek7_pkg::HIST_W-1:1]};

endmodule

// ===== hw/rtl/cek7_packer.sv =====
// ----------------------------------------------------------------------------
// cek7_packer: puncture and byte packing
// Orders the coded bits of one input byte, drops punctured bits, merges them
// behind the partial byte and reports the completed bytes.
// ----------------------------------------------------------------------------
module cek7_packer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic                     last,
  input  logic                     code_rate,
  input  logic [7:0]               g0,
  input  logic [7:0]               g1,
  output cek7_pkg::pack_result_t   result
);

  logic [7:0]  pending;
  logic [2:0]  pcnt;
  logic [7:0]  pending_next;
  logic [2:0]  pcnt_next;
  logic [15:0] seq;
  logic [4:0]  n_bits;
  logic [4:0]  total;
  logic [23:0] acc;
  logic [1:0]  n_bytes;

  // Order coded bits first-out at the MSB; drop G1 of odd bits at rate 2/3
  always_comb begin
    seq = '0;
    if (code_rate == cek7_pkg::RATE_HALF) begin
      for (int k = 0; k < 8; k++) begin
        seq[15-2*k] = g0[k];
        seq[14-2*k] = g1[k];
      end
      n_bits = 5'd16;
    end else begin
      for (int j = 0; j < 4; j++) begin
        seq[15-3*j] = g0[2*j];
        seq[14-3*j] = g1[2*j];
        seq[13-3*j] = g0[2*j+1];
      end
      n_bits = 5'd12;
    end
  end

  // Append the new bits behind the partial byte
  always_comb begin
    acc     = {pending, 16'b0} | ({seq, 8'b0} >> pcnt);
    total   = {2'b00, pcnt} + n_bits;
    n_bytes = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
  end

  assign result.n_bytes = n_bytes;
  assign result.byte0   = acc[23:16];
  assign result.byte1   = acc[15:8];

  // Keep the leftover bits as the new partial byte
  always_comb begin
    case (n_bytes)
      2'd2:    pending_next = acc[7:0];
      2'd1:    pending_next = acc[15:8];
      default: pending_next = acc[23:16];
    endcase
    pcnt_next = total[2:0];
    if (last) begin
      pending_next = '0;
      pcnt_next    = '0;
    end
  end

  // Hold the packing state between input bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      pcnt    <= '0;
    end else if (load) begin
      pending <= pending_next;
      pcnt    <= pcnt_next;
    end
  end

endmodule
